FILE: src/jhs_pkg.sv
package jhs_pkg;

  localparam int TEMP_W   = 16;
  localparam int SUM_W    = TEMP_W + 2;
  localparam int RC_W     = 3;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 16;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic host_wr;     // load one cell of the current bank from the input beat
    logic sweep_wr;    // write one cell of the other bank during a sweep
    logic use_sum;     // sweep write takes the quarter sum, else copies the read data
    logic acc_first;   // accumulator takes the read data
    logic acc_add;     // accumulator adds the read data
    logic toggle_bank; // sweep finished, swap banks
    logic load_out;    // fill the result register
    logic out_read;    // result answers a read
    logic out_data;    // result carries the read data
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

FILE: src/jacobi_heat_stencil_sweep.sv
// channel   direction  handshake              beat contents
// in_       input      in_valid / in_stall    mode, row, col, temperature, sweep_count
// out_      output     out_valid / out_stall  read_temperature, is_read_reply
//
// write and unused-mode beats answer straight from idle, read beats pass through ST_RD
// for the registered ram read; a run beat with a zero sweep_count answers from idle too;
// during a sweep each interior cell reads its four neighbors through the single
// read port of the source bank, one per cycle, border cells read and copy themselves
// synchronous active-low reset clears the sequencer, the bank select and out_valid;
// grid contents are not cleared
// a new beat is taken only while idle and the result register is empty or draining
module jacobi_heat_stencil_sweep #(
  parameter int GRID_SIZE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jhs_pkg::MODE_W-1:0]      in_mode,
  input  logic [jhs_pkg::RC_W-1:0]        in_row,
  input  logic [jhs_pkg::RC_W-1:0]        in_col,
  input  logic [jhs_pkg::TEMP_W-1:0]      in_temperature,
  input  logic [jhs_pkg::COUNT_W-1:0]     in_sweep_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [jhs_pkg::TEMP_W-1:0]      out_read_temperature,
  output logic                            out_is_read_reply
);
  import jhs_pkg::*;

  localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);

  // sequencer to datapath
  cmd_t              cmd;
  status_t           status;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // state machine: beat acceptance, sweep walk over cells and neighbors
  jhs_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_sweep_count (in_sweep_count),
    .out_stall      (out_stall),
    .status         (status),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr)
  );

  // two grid banks, neighbor accumulator, result register
  jhs_datapath #(.GRID_SIZE(GRID_SIZE)) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .wr_addr              (wr_addr),
    .rd_addr              (rd_addr),
    .in_temperature       (in_temperature),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_read_temperature (out_read_temperature),
    .out_is_read_reply    (out_is_read_reply)
  );

endmodule

FILE: src/jhs_ram.sv
module jhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/jhs_datapath.sv
module jhs_datapath #(
  parameter int GRID_SIZE = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  jhs_pkg::cmd_t                            cmd,
  output jhs_pkg::status_t                         status,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   wr_addr,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   rd_addr,
  input  logic [jhs_pkg::TEMP_W-1:0]               in_temperature,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output logic [jhs_pkg::TEMP_W-1:0]               out_read_temperature,
  output logic                                     out_is_read_reply
);
  import jhs_pkg::*;

  localparam int CELLS  = GRID_SIZE * GRID_SIZE;

  logic              cur_bank_r;
  logic [SUM_W-1:0]  acc_r;
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic              out_reply_r;

  logic [TEMP_W-1:0] rdata_a, rdata_b, rdata_src, wdata;
  logic [SUM_W-1:0]  sum;
  logic              we_a, we_b;

  assign rdata_src = cur_bank_r ? rdata_b : rdata_a;
  assign sum       = acc_r + {2'b00, rdata_src};
  assign wdata     = cmd.host_wr ? in_temperature :
                     (cmd.use_sum ? sum[SUM_W-1:2] : rdata_src);

  // host writes hit the current bank, sweep writes the other one
  assign we_a = (cmd.host_wr && !cur_bank_r) || (cmd.sweep_wr && cur_bank_r);
  assign we_b = (cmd.host_wr && cur_bank_r) || (cmd.sweep_wr && !cur_bank_r);

  jhs_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  jhs_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_bank_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.toggle_bank) begin
        cur_bank_r <= !cur_bank_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_first) begin
      acc_r <= {2'b00, rdata_src};
    end else if (cmd.acc_add) begin
      acc_r <= sum;
    end
    if (cmd.load_out) begin
      out_temp_r  <= cmd.out_data ? rdata_src : '0;
      out_reply_r <= cmd.out_read;
    end
  end

  assign status.out_valid     = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_read_temperature = out_temp_r;
  assign out_is_read_reply    = out_reply_r;

endmodule

FILE: src/jhs_ctrl.sv
module jhs_ctrl #(
  parameter int GRID_SIZE = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [jhs_pkg::MODE_W-1:0]             in_mode,
  input  logic [jhs_pkg::RC_W-1:0]               in_row,
  input  logic [jhs_pkg::RC_W-1:0]               in_col,
  input  logic [jhs_pkg::COUNT_W-1:0]            in_sweep_count,
  input  logic                                   out_stall,
  input  jhs_pkg::status_t                       status,
  output jhs_pkg::cmd_t                          cmd,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] wr_addr,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr
);
  import jhs_pkg::*;

  localparam int CELLS  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(GRID_SIZE);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RD    = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(GRID_SIZE - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(GRID_SIZE);

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] sweeps_r, sweeps_nxt;
  logic [ADDR_W-1:0]  at_r, at_nxt;
  logic [IDX_W-1:0]   r_r, r_nxt, c_r, c_nxt;
  logic [2:0]         ph_r, ph_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               on_grid_r, on_grid_nxt;

  logic              out_free, on_grid, interior, cell_done;
  logic [ADDR_W-1:0] cell_addr, nb_addr;

  assign out_free  = !status.out_valid || !out_stall;
  assign on_grid   = (int'(in_row) < GRID_SIZE) && (int'(in_col) < GRID_SIZE);
  assign cell_addr = on_grid ? ADDR_W'(int'(in_row) * GRID_SIZE + int'(in_col)) : '0;
  assign interior  = (r_r != '0) && (c_r != '0) && (r_r != LAST_IDX) && (c_r != LAST_IDX);

  // neighbor order: west, east, north, south
  always_comb begin
    nb_addr = at_r;
    if (interior) begin
      case (ph_r)
        3'd0:    nb_addr = at_r - ADDR_W'(1);
        3'd1:    nb_addr = at_r + ADDR_W'(1);
        3'd2:    nb_addr = at_r - ROW_STEP;
        3'd3:    nb_addr = at_r + ROW_STEP;
        default: nb_addr = at_r;
      endcase
    end
  end

  assign cell_done = (state_r == ST_SWEEP) &&
                     (interior ? (ph_r == 3'd4) : (ph_r == 3'd1));

  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign wr_addr  = (state_r == ST_IDLE) ? cell_addr : at_r;

  always_comb begin
    case (state_r)
      ST_IDLE:  rd_addr = cell_addr;
      ST_RD:    rd_addr = addr_r;
      ST_SWEEP: rd_addr = nb_addr;
      default:  rd_addr = addr_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    sweeps_nxt  = sweeps_r;
    at_nxt      = at_r;
    r_nxt       = r_r;
    c_nxt       = c_r;
    ph_nxt      = ph_r;
    addr_nxt    = addr_r;
    on_grid_nxt = on_grid_r;
    cmd         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && out_free) begin
          case (in_mode)
            MODE_WRITE: begin
              cmd.host_wr  = on_grid;
              cmd.load_out = 1'b1;
            end
            MODE_RUN: begin
              if (in_sweep_count == '0) begin
                cmd.load_out = 1'b1;
              end else begin
                sweeps_nxt = in_sweep_count;
                at_nxt     = '0;
                r_nxt      = '0;
                c_nxt      = '0;
                ph_nxt     = '0;
                state_nxt  = ST_SWEEP;
              end
            end
            MODE_READ: begin
              addr_nxt    = cell_addr;
              on_grid_nxt = on_grid;
              state_nxt   = ST_RD;
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_read = 1'b1;
          cmd.out_data = on_grid_r;
          state_nxt    = ST_IDLE;
        end
      end

      ST_SWEEP: begin
        ph_nxt = ph_r + 3'd1;
        if (interior) begin
          cmd.acc_first = (ph_r == 3'd1);
          cmd.acc_add   = (ph_r == 3'd2) || (ph_r == 3'd3);
        end
        if (cell_done) begin
          cmd.sweep_wr = 1'b1;
          cmd.use_sum  = interior;
          ph_nxt       = '0;
          if ((r_r == LAST_IDX) && (c_r == LAST_IDX)) begin
            cmd.toggle_bank = 1'b1;
            at_nxt          = '0;
            r_nxt           = '0;
            c_nxt           = '0;
            sweeps_nxt      = sweeps_r - COUNT_W'(1);
            if (sweeps_r == COUNT_W'(1)) begin
              state_nxt = ST_FIN;
            end
          end else begin
            at_nxt = at_r + ADDR_W'(1);
            if (c_r == LAST_IDX) begin
              c_nxt = '0;
              r_nxt = r_r + IDX_W'(1);
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweeps_r  <= sweeps_nxt;
    at_r      <= at_nxt;
    r_r       <= r_nxt;
    c_r       <= c_nxt;
    ph_r      <= ph_nxt;
    addr_r    <= addr_nxt;
    on_grid_r <= on_grid_nxt;
  end

endmodule
